/* rtl/spi_eeprom_byte_engine_macros.svh */
// Assertion helpers shared by the checker
`ifndef SPI_EEPROM_BYTE_ENGINE_MACROS_SVH
`define SPI_EEPROM_BYTE_ENGINE_MACROS_SVH

// same-cycle implication
`define SPIEE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPIEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spiee_pkg.sv */
package spiee_pkg;

  localparam int MEM_DEPTH  = 131072;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int CUR_ADDR_W = 24;
  localparam int CAP_W      = 18;

  localparam logic [CAP_W-1:0] CAP_RESET    = 18'd65536;
  localparam logic [CAP_W-1:0] BIG_CAPACITY = 18'h20000;

  localparam logic [7:0] OP_WRITE  = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_STATUS = 8'h05;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_RANGE  = 2'd1;
  localparam logic [1:0] ERR_OPCODE = 2'd2;

endpackage

/* rtl/spiee_in_if.sv */
interface spiee_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic [7:0] byte_index;

  modport source (output valid, output cmd, output data_byte, output byte_index,
                  input ready);
  modport sink (input valid, input cmd, input data_byte, input byte_index,
                output ready);
endinterface

/* rtl/spiee_out_if.sv */
interface spiee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [1:0] error;

  modport source (output valid, output read_byte, output error, input ready);
  modport sink (input valid, input read_byte, input error, output ready);
endinterface

/* rtl/spiee_ram.sv */
module spiee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/spi_eeprom_byte_engine.sv */
// A result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while no result stalls and no sweep runs; the
// single-port store and the output register (whose read data is the store's
// read register) set that figure. Reset: synchronous; all MEM_DEPTH entries are
// then swept to 0xFF, one entry per cycle, req.ready low; config writes are taken.
module spi_eeprom_byte_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  spiee_in_if.sink                             req,
  spiee_out_if.source                          rsp,
  input  logic                                 cfg_wr_en,
  input  logic [spiee_pkg::CAP_W-1:0]          cfg_wr_data
);

  logic [spiee_pkg::CAP_W-1:0]      capacity;
  logic [7:0]                       opcode;
  logic [7:0]                       opcode_next;
  logic [spiee_pkg::CUR_ADDR_W-1:0] cur_address;
  logic [spiee_pkg::CUR_ADDR_W-1:0] cur_address_next;
  logic [spiee_pkg::CUR_ADDR_W-1:0] addr_part;
  logic                             clearing;
  logic [spiee_pkg::ADDR_W-1:0]     clr_addr;
  logic                             out_valid;
  logic [1:0]                       out_err;
  logic                             out_rd_sel;

  logic       accept;
  logic       big;
  logic [1:0] last;
  logic [1:0] sel;
  logic       data_phase;
  logic       addr_ok;
  logic [1:0] err;
  logic       rd_sel;
  logic       item_we;
  logic       item_re;

  logic                         ram_we;
  logic                         ram_re;
  logic [spiee_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                   ram_wdata;
  logic [7:0]                   ram_q;

  assign accept    = req.valid && req.ready;
  assign req.ready = !clearing && (!out_valid || rsp.ready);

  assign big        = (capacity == spiee_pkg::BIG_CAPACITY);
  assign last       = big ? 2'd3 : 2'd2;
  assign data_phase = (req.byte_index > {6'd0, last});
  assign sel        = last - req.byte_index[1:0];
  assign addr_ok    = (cur_address < {6'd0, capacity}) &&
                      (cur_address < spiee_pkg::CUR_ADDR_W'(spiee_pkg::MEM_DEPTH));

  always_comb begin
    case (sel)
      2'd0:    addr_part = {16'd0, req.data_byte};
      2'd1:    addr_part = {8'd0, req.data_byte, 8'd0};
      2'd2:    addr_part = {req.data_byte, 16'd0};
      default: addr_part = '0;
    endcase
  end

  always_comb begin
    opcode_next      = opcode;
    cur_address_next = cur_address;
    err              = spiee_pkg::ERR_NONE;
    rd_sel           = 1'b0;
    item_we          = 1'b0;
    item_re          = 1'b0;
    if (!req.cmd) begin
      opcode_next      = req.data_byte;
      cur_address_next = '0;
    end else if (opcode == spiee_pkg::OP_WRITE || opcode == spiee_pkg::OP_READ) begin
      if (!data_phase) begin
        cur_address_next = cur_address | addr_part;
      end else if (!addr_ok) begin
        err = spiee_pkg::ERR_RANGE;
      end else begin
        if (opcode == spiee_pkg::OP_WRITE) begin
          item_we = 1'b1;
        end else begin
          item_re = 1'b1;
          rd_sel  = 1'b1;
        end
        cur_address_next = cur_address + spiee_pkg::CUR_ADDR_W'(1);
      end
    end else if (opcode != spiee_pkg::OP_STATUS) begin
      err = spiee_pkg::ERR_OPCODE;
    end
  end

  assign ram_we    = clearing || (accept && item_we);
  assign ram_re    = accept && item_re;
  assign ram_addr  = clearing ? clr_addr : cur_address[spiee_pkg::ADDR_W-1:0];
  assign ram_wdata = clearing ? spiee_pkg::ERASED_BYTE : req.data_byte;

  spiee_ram #(
    .WIDTH (8),
    .DEPTH (spiee_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= spiee_pkg::CAP_RESET;
      opcode      <= '0;
      cur_address <= '0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      out_err     <= spiee_pkg::ERR_NONE;
      out_rd_sel  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + spiee_pkg::ADDR_W'(1);
        if (clr_addr == spiee_pkg::ADDR_W'(spiee_pkg::MEM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        opcode      <= opcode_next;
        cur_address <= cur_address_next;
        out_valid   <= 1'b1;
        out_err     <= err;
        out_rd_sel  <= rd_sel;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.error     = out_err;
  assign rsp.read_byte = out_rd_sel ? ram_q : 8'd0;

endmodule

/* rtl/spiee_checker.sv */
`include "spi_eeprom_byte_engine_macros.svh"

module spiee_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_cmd,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_byte,
  input logic [1:0] rsp_error
);

  `SPIEE_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_error), "stalled result beat changed")
  `SPIEE_ASSERT_NEXT(a_one_cycle, clk, rst, req_valid && req_ready, rsp_valid, "accepted beat gave no result next cycle")
  `SPIEE_ASSERT_NEXT(a_cmd_quiet, clk, rst, req_valid && req_ready && !req_cmd, rsp_read_byte == 8'd0 && rsp_error == 2'd0, "command beat gave nonzero result")
  `SPIEE_ASSERT_NOW(a_err_zero_data, clk, rst, rsp_valid && rsp_error != 2'd0, rsp_read_byte == 8'd0 && rsp_error != 2'd3, "error result carries data or bad code")

endmodule

bind spi_eeprom_byte_engine spiee_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_cmd       (req.cmd),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_byte (rsp.read_byte),
  .rsp_error     (rsp.error)
);
